// ===== rtl/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// pfi_pkg
// shared types, opcodes and helpers of the particle force integrator
// ----------------------------------------------------------------------------
package pfi_pkg;

   localparam logic [3:0] OP_CLEAR     = 4'd0;
   localparam logic [3:0] OP_ADD       = 4'd1;
   localparam logic [3:0] OP_REPEL     = 4'd2;
   localparam logic [3:0] OP_ATTRACT   = 4'd3;
   localparam logic [3:0] OP_CW        = 4'd4;
   localparam logic [3:0] OP_CCW       = 4'd5;
   localparam logic [3:0] OP_DAMP      = 4'd6;
   localparam logic [3:0] OP_INTEGRATE = 4'd7;
   localparam logic [3:0] OP_BOUNCE    = 4'd8;
   localparam logic [3:0] OP_HIT       = 4'd9;
   localparam logic [3:0] OP_LOADPOS   = 4'd10;
   localparam logic [3:0] OP_LOADVEL   = 4'd11;

   localparam logic [2:0] CSR_DAMPING = 3'd0;
   localparam logic [2:0] CSR_WALL_W  = 3'd1;
   localparam logic [2:0] CSR_WALL_H  = 3'd2;
   localparam logic [2:0] CSR_HIT_R   = 3'd3;
   localparam logic [2:0] CSR_PINNED  = 3'd4;

   localparam logic [15:0] DAMPING_RST = 16'd3277;
   localparam logic [15:0] WALL_W_RST  = 16'd1024;
   localparam logic [15:0] WALL_H_RST  = 16'd768;
   localparam logic [31:0] BOUNCE_GAIN = 32'd19661;
   localparam int          GAIN_SHIFT  = 16;

   localparam int ROOT_W = 32;
   localparam int DEN_W  = 33;
   localparam int REM_W  = 36;

   localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
   localparam logic signed [40:0] SAT_MIN = -41'sd2147483648;

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC, S_SQX, S_SQY, S_SQRT, S_LEN, S_PCT, S_MULM, S_UX, S_MULX,
      S_UY, S_MULY, S_APPLY, S_DAMPX, S_DAMPY, S_BNCX, S_BNCY, S_RESP
   } pfi_state_type;

   typedef enum logic {IT_SQRT, IT_DIV} pfi_mode_type;

   typedef struct packed {
      logic         start;
      pfi_mode_type mode;
   } pfi_it_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pfi_it_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
      else if (v < SAT_MIN) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
      return r;
   endfunction

   // magnitude and sign back to a 33-bit signed value
   function automatic logic signed [32:0] apply_sign(input logic neg, input logic [31:0] m);
      logic signed [32:0] r;
      r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      return r;
   endfunction

endpackage

// ===== rtl/pfi_iter_unit.sv =====
// ----------------------------------------------------------------------------
// pfi_iter_unit
// shared bit-serial square root and restoring divider
// ----------------------------------------------------------------------------
module pfi_iter_unit import pfi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pfi_it_ctrl_type     ctrl_in,
   input  logic [63:0]         operand_in,
   input  logic [DEN_W-1:0]    divisor_in,
   output pfi_it_stat_type     status_out,
   output logic [ROOT_W-1:0]   result_out
);

   // quotients stay below 2^(FRAC_BITS+2), so only that many steps run
   localparam int DIV_STEPS = FRAC_BITS + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   pfi_mode_type      mode_ff, mode_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [63:0]       shift_ff, shift_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [REM_W-1:0]  cand, trial;
   logic              take;

   always_comb begin
      if (mode_ff == IT_SQRT) begin
         cand  = {rem_ff[REM_W-3:0], shift_ff[63:62]};
         trial = REM_W'({root_ff, 2'b01});
      end else begin
         cand  = {rem_ff[REM_W-2:0], shift_ff[63]};
         trial = REM_W'(den_ff);
      end
      take = (cand >= trial);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      root_in  = root_ff;
      den_in   = den_ff;
      if (ctrl_in.start) begin
         busy_in = 1'b1;
         mode_in = ctrl_in.mode;
         root_in = '0;
         den_in  = divisor_in;
         if (ctrl_in.mode == IT_SQRT) begin
            cnt_in   = 6'(ROOT_W);
            rem_in   = '0;
            shift_in = operand_in;
         end else begin
            cnt_in   = 6'(DIV_STEPS);
            rem_in   = REM_W'(operand_in >> DIV_STEPS);
            shift_in = operand_in << (64 - DIV_STEPS);
         end
      end else if (busy_ff) begin
         rem_in   = take ? (cand - trial) : cand;
         root_in  = {root_ff[ROOT_W-2:0], take};
         shift_in = (mode_ff == IT_SQRT) ? (shift_ff << 2) : (shift_ff << 1);
         cnt_in   = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff  <= mode_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      root_ff  <= root_in;
      den_ff   <= den_in;
   end

   assign status_out.busy = busy_ff;
   assign status_out.done = done_ff;
   assign result_out      = root_ff;

endmodule

// ===== rtl/particle_force_integrator_core.sv =====
// ----------------------------------------------------------------------------
// particle_force_integrator_core
// one 2-d particle with force accumulation, field forces and euler stepping
// ----------------------------------------------------------------------------
// Takes one beat at a time and returns one result beat per request; req_stall
// stays high from acceptance until the result beat is taken. Clear, add, load
// and integrate go from execute straight to the result; damping adds the DAMPX
// and DAMPY states, and bounce adds BNCX and BNCY only when a wall is hit. The
// hit test, and radial and swirl ops that find a zero length or a point out of
// range, wait only for the square root; an applied radial or swirl op also waits
// for the falloff divide (skipped with a zero radius) and the two normalizing
// divides. The shared bit-serial unit runs a 32-step square root for the length
// and FRAC_BITS+2 steps for each divide, one bit a cycle.
module particle_force_integrator_core import pfi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic [30:0]        req_range_radius,
   input  logic signed [31:0] req_strength,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_reaction_x,
   output logic signed [31:0] rsp_reaction_y,
   output logic               rsp_in_range,
   output logic               rsp_hit_flag,
   output logic               rsp_collided,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

   pfi_state_type state_ff, state_in;

   logic [15:0] damping_ff, wall_w_ff, wall_h_ff, hit_r_ff;
   logic        pinned_ff;

   logic [3:0]         op_ff;
   logic signed [31:0] ix_ff, iy_ff, str_ff;
   logic [30:0]        rad_ff;

   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff, frc_x_ff, frc_y_ff;
   logic signed [31:0] react_x_ff, react_y_ff;
   logic               hit_ff, inr_ff, col_ff;

   logic [32:0] ax_ff, ay_ff, len_ff;
   logic        dneg_x_ff, dneg_y_ff, half_ff;
   logic [63:0] sqsum_ff;
   logic [31:0] m_mag_ff, px_mag_ff, py_mag_ff, damp_x_ff;
   logic [31:0] mul_a_ff, mul_b_ff;
   logic [63:0] prod;

   pfi_it_ctrl_type    it_ctrl;
   pfi_it_stat_type    it_stat;
   logic [63:0]        it_operand;
   logic [DEN_W-1:0]   it_divisor;
   logic [ROOT_W-1:0]  it_result;

   pfi_iter_unit #(.FRAC_BITS(FRAC_BITS)) u_iter (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (it_ctrl),
      .operand_in (it_operand),
      .divisor_in (it_divisor),
      .status_out (it_stat),
      .result_out (it_result)
   );

   // shared multiplier, captured by the state after the operands are set
   assign prod = 64'(mul_a_ff) * 64'(mul_b_ff);

   // difference vector and its scaled halves for the length
   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay;
   logic               half;
   logic [31:0]        hx, hy_reg;
   logic [32:0]        len_w;
   logic               is_force, force_go;
   logic [31:0]        ux_clamp;

   always_comb begin
      dx       = $signed({pos_x_ff[31], pos_x_ff}) - $signed({ix_ff[31], ix_ff});
      dy       = $signed({pos_y_ff[31], pos_y_ff}) - $signed({iy_ff[31], iy_ff});
      ax       = dx[32] ? 33'(-dx) : 33'(dx);
      ay       = dy[32] ? 33'(-dy) : 33'(dy);
      half     = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
      hx       = half ? ax[32:1] : ax[31:0];
      hy_reg   = half_ff ? ay_ff[32:1] : ay_ff[31:0];
      len_w    = half_ff ? {it_result, 1'b0} : {1'b0, it_result};
      is_force = (op_ff == OP_REPEL) || (op_ff == OP_ATTRACT) ||
                 (op_ff == OP_CW) || (op_ff == OP_CCW);
      force_go = (len_ff != '0) && ((rad_ff == '0) || (len_ff <= {2'b00, rad_ff}));
      ux_clamp = (it_result > ONE_Q) ? ONE_Q : it_result;
   end

   // simple-op and bounce results
   logic signed [31:0] int_vx, int_vy, int_px, int_py;
   logic signed [31:0] max_x, max_y, bnc_px, bnc_py, bnc_vx, bnc_vy;
   logic               bnc_hx, bnc_hy;

   always_comb begin
      int_vx = sat32(41'(vel_x_ff) + 41'(frc_x_ff));
      int_vy = sat32(41'(vel_y_ff) + 41'(frc_y_ff));
      int_px = sat32(41'(pos_x_ff) + 41'(int_vx));
      int_py = sat32(41'(pos_y_ff) + 41'(int_vy));
      max_x  = sat32($signed(41'(wall_w_ff) << FRAC_BITS));
      max_y  = sat32($signed(41'(wall_h_ff) << FRAC_BITS));
      bnc_hx = (pos_x_ff > max_x) || pos_x_ff[31];
      bnc_hy = (pos_y_ff > max_y) || pos_y_ff[31];
      bnc_px = pos_x_ff;
      bnc_vx = vel_x_ff;
      bnc_py = pos_y_ff;
      bnc_vy = vel_y_ff;
      if (bnc_hx) begin
         bnc_px = (pos_x_ff > max_x) ? max_x : 32'sd0;
         bnc_vx = sat32(-41'(vel_x_ff));
      end
      if (bnc_hy) begin
         bnc_py = (pos_y_ff > max_y) ? max_y : 32'sd0;
         bnc_vy = sat32(-41'(vel_y_ff));
      end
   end

   // force increment of the radial and swirl ops
   logic signed [32:0] px_s, py_s;
   logic signed [33:0] fx, fy;
   logic signed [31:0] inc_x, inc_y;

   always_comb begin
      px_s = apply_sign(str_ff[31] ^ dneg_x_ff, px_mag_ff);
      py_s = apply_sign(str_ff[31] ^ dneg_y_ff, py_mag_ff);
      case (op_ff)
         OP_REPEL: begin
            fx = 34'(px_s);
            fy = 34'(py_s);
         end
         OP_ATTRACT: begin
            fx = -34'(px_s);
            fy = -34'(py_s);
         end
         OP_CW: begin
            fx = -34'(py_s);
            fy = 34'(px_s);
         end
         default: begin
            fx = 34'(py_s);
            fy = -34'(px_s);
         end
      endcase
      inc_x = sat32(41'(fx));
      inc_y = sat32(41'(fy));
   end

   logic signed [32:0] damp_y_s;
   assign damp_y_s = apply_sign(vel_y_ff[31], prod[GAIN_SHIFT +: 32]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: begin
            if (is_force || op_ff == OP_HIT) state_in = S_SQX;
            else if (op_ff == OP_DAMP) state_in = S_DAMPX;
            else if (op_ff == OP_BOUNCE && (bnc_hx || bnc_hy)) state_in = S_BNCX;
            else state_in = S_RESP;
         end
         S_SQX:  state_in = S_SQY;
         S_SQY:  state_in = S_SQRT;
         S_SQRT: if (it_stat.done) state_in = S_LEN;
         S_LEN: begin
            if (op_ff == OP_HIT || !force_go) state_in = S_RESP;
            else if (rad_ff == '0) state_in = S_MULM;
            else state_in = S_PCT;
         end
         S_PCT:   if (it_stat.done) state_in = S_MULM;
         S_MULM:  state_in = S_UX;
         S_UX:    if (it_stat.done) state_in = S_MULX;
         S_MULX:  state_in = S_UY;
         S_UY:    if (it_stat.done) state_in = S_MULY;
         S_MULY:  state_in = S_APPLY;
         S_APPLY: state_in = S_RESP;
         S_DAMPX: state_in = S_DAMPY;
         S_DAMPY: state_in = S_RESP;
         S_BNCX:  state_in = S_BNCY;
         S_BNCY:  state_in = S_RESP;
         S_RESP:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // shared unit requests
   always_comb begin
      it_ctrl.start = 1'b0;
      it_ctrl.mode  = IT_DIV;
      it_operand    = '0;
      it_divisor    = len_ff;
      case (state_ff)
         S_SQY: begin
            it_ctrl.start = 1'b1;
            it_ctrl.mode  = IT_SQRT;
            it_operand    = sqsum_ff + prod;
         end
         S_LEN: begin
            it_ctrl.start = is_force && force_go && (rad_ff != '0);
            it_operand    = 64'({2'b00, rad_ff} - len_ff) << FRAC_BITS;
            it_divisor    = DEN_W'(rad_ff);
         end
         S_MULM: begin
            it_ctrl.start = 1'b1;
            it_operand    = 64'(ax_ff) << FRAC_BITS;
         end
         S_MULX: begin
            it_ctrl.start = 1'b1;
            it_operand    = 64'(ay_ff) << FRAC_BITS;
         end
         default: it_ctrl.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         damping_ff <= DAMPING_RST;
         wall_w_ff  <= WALL_W_RST;
         wall_h_ff  <= WALL_H_RST;
         hit_r_ff   <= '0;
         pinned_ff  <= 1'b0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         vel_x_ff   <= '0;
         vel_y_ff   <= '0;
         frc_x_ff   <= '0;
         frc_y_ff   <= '0;
         hit_ff     <= 1'b0;
         react_x_ff <= '0;
         react_y_ff <= '0;
         inr_ff     <= 1'b0;
         col_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DAMPING: damping_ff <= csr_wdata;
               CSR_WALL_W:  wall_w_ff  <= csr_wdata;
               CSR_WALL_H:  wall_h_ff  <= csr_wdata;
               CSR_HIT_R:   hit_r_ff   <= csr_wdata;
               CSR_PINNED:  pinned_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  react_x_ff <= '0;
                  react_y_ff <= '0;
                  inr_ff     <= 1'b0;
                  col_ff     <= 1'b0;
               end
            end
            S_EXEC: begin
               case (op_ff)
                  OP_CLEAR: begin
                     frc_x_ff <= '0;
                     frc_y_ff <= '0;
                  end
                  OP_ADD: begin
                     frc_x_ff <= sat32(41'(frc_x_ff) + 41'(ix_ff));
                     frc_y_ff <= sat32(41'(frc_y_ff) + 41'(iy_ff));
                  end
                  OP_INTEGRATE: begin
                     if (!pinned_ff) begin
                        vel_x_ff <= int_vx;
                        vel_y_ff <= int_vy;
                        pos_x_ff <= int_px;
                        pos_y_ff <= int_py;
                     end
                  end
                  OP_BOUNCE: begin
                     pos_x_ff <= bnc_px;
                     pos_y_ff <= bnc_py;
                     vel_x_ff <= bnc_vx;
                     vel_y_ff <= bnc_vy;
                     col_ff   <= bnc_hx || bnc_hy;
                  end
                  OP_LOADPOS: begin
                     pos_x_ff <= ix_ff;
                     pos_y_ff <= iy_ff;
                  end
                  OP_LOADVEL: begin
                     vel_x_ff <= ix_ff;
                     vel_y_ff <= iy_ff;
                  end
                  default: ;
               endcase
            end
            S_LEN: begin
               if (op_ff == OP_HIT) begin
                  hit_ff <= (41'(len_ff) < (41'(hit_r_ff) << FRAC_BITS));
               end
            end
            S_APPLY: begin
               frc_x_ff   <= sat32(41'(frc_x_ff) + 41'(inc_x));
               frc_y_ff   <= sat32(41'(frc_y_ff) + 41'(inc_y));
               react_x_ff <= sat32(-41'(inc_x));
               react_y_ff <= sat32(-41'(inc_y));
               inr_ff     <= 1'b1;
            end
            S_DAMPY: begin
               frc_x_ff <= sat32(41'(frc_x_ff) -
                                 41'(apply_sign(vel_x_ff[31], damp_x_ff)));
               frc_y_ff <= sat32(41'(frc_y_ff) - 41'(damp_y_s));
            end
            S_BNCX: vel_x_ff <= 32'(apply_sign(vel_x_ff[31], prod[GAIN_SHIFT +: 32]));
            S_BNCY: vel_y_ff <= 32'(apply_sign(vel_y_ff[31], prod[GAIN_SHIFT +: 32]));
            default: ;
         endcase
      end

      // datapath registers without reset
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_ff  <= req_opcode;
               ix_ff  <= req_in_x;
               iy_ff  <= req_in_y;
               rad_ff <= req_range_radius;
               str_ff <= req_strength;
            end
         end
         S_EXEC: begin
            ax_ff     <= ax;
            ay_ff     <= ay;
            dneg_x_ff <= dx[32];
            dneg_y_ff <= dy[32];
            half_ff   <= half;
            if (op_ff == OP_DAMP) begin
               mul_a_ff <= mag32(vel_x_ff);
               mul_b_ff <= 32'(damping_ff);
            end else if (op_ff == OP_BOUNCE) begin
               mul_a_ff <= mag32(bnc_vx);
               mul_b_ff <= BOUNCE_GAIN;
            end else begin
               mul_a_ff <= hx;
               mul_b_ff <= hx;
            end
         end
         S_SQX: begin
            sqsum_ff <= prod;
            mul_a_ff <= hy_reg;
            mul_b_ff <= hy_reg;
         end
         S_SQRT: if (it_stat.done) len_ff <= len_w;
         S_LEN: begin
            mul_a_ff <= mag32(str_ff);
            mul_b_ff <= ONE_Q;
         end
         S_PCT: if (it_stat.done) mul_b_ff <= it_result;
         S_MULM: m_mag_ff <= prod[FRAC_BITS +: 32];
         S_UX: begin
            if (it_stat.done) begin
               mul_a_ff <= m_mag_ff;
               mul_b_ff <= ux_clamp;
            end
         end
         S_MULX: px_mag_ff <= prod[FRAC_BITS +: 32];
         S_UY: begin
            if (it_stat.done) begin
               mul_a_ff <= m_mag_ff;
               mul_b_ff <= ux_clamp;
            end
         end
         S_MULY: py_mag_ff <= prod[FRAC_BITS +: 32];
         S_DAMPX: begin
            damp_x_ff <= prod[GAIN_SHIFT +: 32];
            mul_a_ff  <= mag32(vel_y_ff);
         end
         S_BNCX: mul_a_ff <= mag32(vel_y_ff);
         default: ;
      endcase
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_vel_x      = vel_x_ff;
   assign rsp_vel_y      = vel_y_ff;
   assign rsp_force_x    = frc_x_ff;
   assign rsp_force_y    = frc_y_ff;
   assign rsp_reaction_x = react_x_ff;
   assign rsp_reaction_y = react_y_ff;
   assign rsp_in_range   = inr_ff;
   assign rsp_hit_flag   = hit_ff;
   assign rsp_collided   = col_ff;

`ifndef ASSERT_OFF
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result beat shown while request side is open");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      it_stat.done |-> (state_ff == S_SQRT || state_ff == S_PCT ||
                        state_ff == S_UX || state_ff == S_UY))
      else $error("iterative unit finished outside a wait state");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      it_ctrl.start |-> !it_stat.busy)
      else $error("iterative unit started while busy");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_in_range && rsp_collided))
      else $error("in_range and collided both set");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// regression for particle_force_integrator_core: table-driven directed beats,
// then random beats with random idling on both sides, every result checked
// against a typed-in view or a behavioral particle model
// ----------------------------------------------------------------------------
module testbench import pfi_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam longint CYCLE_LIMIT = 1_500_000;

   typedef struct {
      logic [3:0]         op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [30:0]        rad;
      logic signed [31:0] str;
   } beat_type;

   typedef struct {
      logic signed [31:0] px, py, vx, vy, fx, fy, rx, ry;
      logic               inr, hit, col;
   } particle_view_type;

   typedef struct {
      beat_type b;
      logic  known;
      particle_view_type v;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_opcode = '0;
   logic signed [31:0] req_in_x = '0, req_in_y = '0, req_strength = '0;
   logic [30:0] req_range_radius = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_vel_x, rsp_vel_y;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_reaction_x, rsp_reaction_y;
   logic rsp_in_range, rsp_hit_flag, rsp_collided;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   particle_force_integrator_core #(.FRAC_BITS(FRAC)) u_dut (.*);

   always #5 clock = ~clock;

   // particle model state
   longint unsigned damp_gain, wall_w, wall_h, hit_r, pin;
   longint pos_x, pos_y, vel_x, vel_y, frc_x, frc_y;
   bit hit_st;

   particle_view_type expected_views[$];
   int mismatches = 0;
   int idle_pct = 29;
   longint cycles = 0;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absval(longint a);
      return a < 0 ? longint'(-a) : longint'(a);
   endfunction

   function automatic longint scale_trunc(longint a, longint unsigned b, int sh);
      longint unsigned m;
      m = (absval(a) * b) >> sh;
      return a < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v -= res + bt;
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned dist_len(longint unsigned ax, longint unsigned ay);
      int s;
      longint unsigned hx, hy;
      s = ((ax >> 31) | (ay >> 31)) != 0 ? 1 : 0;
      hx = ax >> s;
      hy = ay >> s;
      return int_root(hx * hx + hy * hy) << s;
   endfunction

   task automatic model_reset();
      damp_gain = DAMPING_RST; wall_w = WALL_W_RST; wall_h = WALL_H_RST;
      hit_r = 0; pin = 0;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; frc_x = 0; frc_y = 0;
      hit_st = 0;
   endtask

   function automatic particle_view_type particle_step(beat_type b);
      particle_view_type v;
      longint ix, iy, str, dx, dy, m, px, py, fx, fy, incx, incy, mx, my;
      longint unsigned r, ax, ay, len, pct, ux, uy;
      longint rx, ry;
      bit inr, col;
      ix = b.x; iy = b.y; str = b.str; r = b.rad;
      rx = 0; ry = 0; inr = 0; col = 0;
      case (b.op)
         OP_CLEAR: begin frc_x = 0; frc_y = 0; end
         OP_ADD: begin
            frc_x = clip32(frc_x + ix);
            frc_y = clip32(frc_y + iy);
         end
         OP_REPEL, OP_ATTRACT, OP_CW, OP_CCW: begin
            dx = pos_x - ix; dy = pos_y - iy;
            ax = absval(dx); ay = absval(dy);
            len = dist_len(ax, ay);
            if (len != 0 && (r == 0 || len <= r)) begin
               pct = (r == 0) ? (64'd1 << FRAC) : ((r - len) << FRAC) / r;
               m = scale_trunc(str, pct, FRAC);
               ux = (ax << FRAC) / len; uy = (ay << FRAC) / len;
               if (ux > (64'd1 << FRAC)) ux = 64'd1 << FRAC;
               if (uy > (64'd1 << FRAC)) uy = 64'd1 << FRAC;
               px = scale_trunc(dx < 0 ? -m : m, ux, FRAC);
               py = scale_trunc(dy < 0 ? -m : m, uy, FRAC);
               case (b.op)
                  OP_REPEL:   begin fx = px;  fy = py;  end
                  OP_ATTRACT: begin fx = -px; fy = -py; end
                  OP_CW:      begin fx = -py; fy = px;  end
                  default:    begin fx = py;  fy = -px; end
               endcase
               incx = clip32(fx); incy = clip32(fy);
               frc_x = clip32(frc_x + incx);
               frc_y = clip32(frc_y + incy);
               rx = clip32(-incx); ry = clip32(-incy);
               inr = 1;
            end
         end
         OP_DAMP: begin
            frc_x = clip32(frc_x - scale_trunc(vel_x, damp_gain, 16));
            frc_y = clip32(frc_y - scale_trunc(vel_y, damp_gain, 16));
         end
         OP_INTEGRATE: begin
            if (pin == 0) begin
               vel_x = clip32(vel_x + frc_x);
               vel_y = clip32(vel_y + frc_y);
               pos_x = clip32(pos_x + vel_x);
               pos_y = clip32(pos_y + vel_y);
            end
         end
         OP_BOUNCE: begin
            mx = clip32(longint'(wall_w << FRAC));
            my = clip32(longint'(wall_h << FRAC));
            if (pos_x > mx || pos_x < 0) begin
               pos_x = pos_x > mx ? mx : 0;
               vel_x = clip32(-vel_x);
               col = 1;
            end
            if (pos_y > my || pos_y < 0) begin
               pos_y = pos_y > my ? my : 0;
               vel_y = clip32(-vel_y);
               col = 1;
            end
            if (col) begin
               vel_x = scale_trunc(vel_x, BOUNCE_GAIN, 16);
               vel_y = scale_trunc(vel_y, BOUNCE_GAIN, 16);
            end
         end
         OP_HIT: begin
            len = dist_len(absval(pos_x - ix), absval(pos_y - iy));
            hit_st = len < (hit_r << FRAC);
         end
         OP_LOADPOS: begin pos_x = ix; pos_y = iy; end
         OP_LOADVEL: begin vel_x = ix; vel_y = iy; end
         default: ;
      endcase
      v.px = pos_x[31:0]; v.py = pos_y[31:0]; v.vx = vel_x[31:0]; v.vy = vel_y[31:0];
      v.fx = frc_x[31:0]; v.fy = frc_y[31:0]; v.rx = rx[31:0]; v.ry = ry[31:0];
      v.inr = inr; v.hit = hit_st; v.col = col;
      return v;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DAMPING: damp_gain = val;
         CSR_WALL_W:  wall_w = val;
         CSR_WALL_H:  wall_h = val;
         CSR_HIT_R:   hit_r = val;
         default:     pin = val[0];
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // one beat; when check_known the typed-in result replaces the model's
   // valid stays high into the next beat unless the sender idles
   task automatic send_beat(beat_type b, bit check_known, particle_view_type kv);
      particle_view_type v;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= b.op; req_in_x <= b.x; req_in_y <= b.y;
      req_range_radius <= b.rad; req_strength <= b.str;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = particle_step(b);
      expected_views.push_back(check_known ? kv : v);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 2 * 65536 * 1024)) - 32'sd65536000;
         3: return $signed($urandom_range(0, 65536 * 8)) - 32'sd262144;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic beat_type rand_beat();
      beat_type b;
      int k;
      k = $urandom_range(99);
      if (k < 40) b.op = 4'($urandom_range(OP_REPEL, OP_CCW));
      else if (k < 97) b.op = 4'($urandom_range(OP_CLEAR, OP_LOADVEL));
      else b.op = 4'($urandom_range(12, 15));
      b.x = rand_word(); b.y = rand_word(); b.str = rand_word();
      case ($urandom_range(3))
         0: b.rad = '0;
         1: b.rad = 31'h7FFF_FFFF;
         2: b.rad = 31'($urandom_range(1, 65536 * 2000));
         default: b.rad = 31'($urandom);
      endcase
      return b;
   endfunction

   // result checking
   always @(posedge clock) begin
      particle_view_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            e = expected_views.pop_front();
            if (rsp_pos_x !== e.px || rsp_pos_y !== e.py || rsp_vel_x !== e.vx ||
                rsp_vel_y !== e.vy || rsp_force_x !== e.fx || rsp_force_y !== e.fy ||
                rsp_reaction_x !== e.rx || rsp_reaction_y !== e.ry ||
                rsp_in_range !== e.inr || rsp_hit_flag !== e.hit ||
                rsp_collided !== e.col) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch cycle %0d exp pos %h %h vel %h %h frc %h %h re %h %h %b%b%b",
                     cycles, e.px, e.py, e.vx, e.vy, e.fx, e.fy, e.rx, e.ry,
                     e.inr, e.hit, e.col);
                  $display("                   got pos %h %h vel %h %h frc %h %h re %h %h %b%b%b",
                     rsp_pos_x, rsp_pos_y, rsp_vel_x, rsp_vel_y, rsp_force_x,
                     rsp_force_y, rsp_reaction_x, rsp_reaction_y, rsp_in_range,
                     rsp_hit_flag, rsp_collided);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("particle_force_integrator_core regression: fail");
         $finish;
      end
   end

   row_type rows[$];

   function automatic row_type mk(logic [3:0] op, logic signed [31:0] x, logic signed [31:0] y,
                                  logic [30:0] rad, logic signed [31:0] str);
      row_type r;
      r.b.op = op; r.b.x = x; r.b.y = y; r.b.rad = rad; r.b.str = str;
      r.known = 0;
      r.v = '{default: '0};
      return r;
   endfunction

   initial begin
      row_type r;
      beat_type b;
      model_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      r = mk(OP_CLEAR, 0, 0, 0, 0); r.known = 1; rows.push_back(r);
      r = mk(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0); r.known = 1;
      r.v.fx = 32'sh7FFF_FFFF; r.v.fy = 32'sh8000_0000; rows.push_back(r);
      r = mk(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0); r.known = 1;
      r.v.fx = 32'sh7FFF_FFFF; r.v.fy = 32'sh8000_0000; rows.push_back(r);
      // zero-length difference: no force
      r = mk(OP_REPEL, 0, 0, 0, 32'sh0001_0000); r.known = 1;
      r.v.fx = 32'sh7FFF_FFFF; r.v.fy = 32'sh8000_0000; rows.push_back(r);
      rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
      rows.push_back(mk(OP_REPEL, 32'sh0003_0000, 32'sh0004_0000, 0, 32'sh0002_0000));
      rows.push_back(mk(OP_ATTRACT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
      rows.push_back(mk(OP_CW, 32'sh0001_0000, 0, 31'h0004_0000, 32'sh8000_0000));
      rows.push_back(mk(OP_CCW, 0, 32'sh0001_0000, 31'h7FFF_FFFF, 32'sh0010_0000));
      // out of range
      rows.push_back(mk(OP_REPEL, 32'sh0100_0000, 0, 31'h0000_0001, 32'sh0010_0000));
      rows.push_back(mk(OP_LOADVEL, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0));
      rows.push_back(mk(OP_DAMP, 0, 0, 0, 0));
      rows.push_back(mk(OP_INTEGRATE, 0, 0, 0, 0));
      rows.push_back(mk(OP_LOADPOS, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0));
      rows.push_back(mk(OP_BOUNCE, 0, 0, 0, 0));
      rows.push_back(mk(OP_HIT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
      rows.push_back(mk(OP_LOADPOS, 32'sh0010_0000, 32'sh0010_0000, 0, 0));
      rows.push_back(mk(OP_BOUNCE, 0, 0, 0, 0));
      rows.push_back(mk(OP_HIT, 32'sh0010_0000, 32'sh0010_0000, 0, 0));
      rows.push_back(mk(4'd15, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 31'h7FFF_FFFF, 32'shFFFF_FFFF));
      rows.push_back(mk(4'd12, 0, 0, 0, 0));

      foreach (rows[i]) send_beat(rows[i].b, rows[i].known, rows[i].v);
      drain();

      write_reg(CSR_HIT_R, 16'd40);
      write_reg(CSR_PINNED, 16'd1);
      write_reg(CSR_DAMPING, 16'hFFFF);
      write_reg(CSR_WALL_W, 16'd0);
      write_reg(CSR_WALL_H, 16'hFFFF);

      for (int i = 0; i < 1730; i++) begin
         if (i == 250) idle_pct = 0;
         if (i == 450) idle_pct = 29;
         if (i % 350 == 349) begin
            drain();
            write_reg(CSR_DAMPING, 16'($urandom));
            write_reg(CSR_WALL_W, (i % 700 == 349) ? 16'hFFFF : 16'($urandom_range(0, 2000)));
            write_reg(CSR_WALL_H, (i % 700 == 349) ? 16'd0 : 16'($urandom_range(0, 2000)));
            write_reg(CSR_HIT_R, 16'($urandom));
            write_reg(CSR_PINNED, 16'($urandom_range(1)));
         end
         b = rand_beat();
         // keep the particle near the field sources most of the time
         if (i % 40 == 0) begin
            b.op = OP_LOADPOS;
            b.x = $signed($urandom_range(0, 65536 * 512));
            b.y = $signed($urandom_range(0, 65536 * 512));
         end
         send_beat(b, 0, '{default: '0});
      end
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      if (mismatches == 0) begin
         $display("particle_force_integrator_core regression: pass");
      end else begin
         $display("particle_force_integrator_core regression: fail");
      end
      $finish;
   end

   // leftover expectations are caught by the wait above timing out
endmodule
